// ===== rtl/core/mlfc_pkg.sv =====
// package for the collision log recovery block
// widths, status codes and sequencer states; no dependencies
package mlfc_pkg;
    localparam int unsigned WIDTH_DEF = 64;
    localparam logic [63:0] GROUP_ORDER_RST = 64'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EQUAL = 2'd1,
        ST_NOINV = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED,
        S_SUB,
        S_DIV,
        S_DSTEP,
        S_MUL,
        S_MSTEP,
        S_TUPD,
        S_FMUL,
        S_FSTEP,
        S_DONE
    } t_state;
endpackage

// ===== rtl/core/mlfc_serial.sv =====
// bit-serial arithmetic unit: one restoring-division or double-and-add step per cycle
// depends on mlfc_pkg
module mlfc_serial #(
    parameter int unsigned WIDTH = mlfc_pkg::WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_mode_mul,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_n,
    output logic             o_busy,
    output logic [WIDTH-1:0] o_quo,
    output logic [WIDTH-1:0] o_rem
);
    localparam int unsigned CW = $clog2(WIDTH + 1);

    logic             r_busy;
    logic             r_mul;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_q;
    logic [WIDTH-1:0] r_r;
    logic [WIDTH-1:0] r_d;
    logic [WIDTH:0]   w_sh;
    logic [WIDTH:0]   w_sum;
    logic [WIDTH:0]   w_dbl;
    logic [WIDTH-1:0] w_acc;
    logic [WIDTH-1:0] w_base;

    // division: r_q shifts dividend out / quotient in, r_r is partial remainder
    assign w_sh = {r_r, r_q[WIDTH-1]};
    // multiply: r_r acc, r_d base, r_q multiplier shifting right
    assign w_sum = {1'b0, r_r} + {1'b0, r_d};
    assign w_dbl = {1'b0, r_d} + {1'b0, r_d};
    always_comb begin
        w_acc  = (w_sum >= {1'b0, i_n}) ? WIDTH'(w_sum - {1'b0, i_n}) : w_sum[WIDTH-1:0];
        w_base = (w_dbl >= {1'b0, i_n}) ? WIDTH'(w_dbl - {1'b0, i_n}) : w_dbl[WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(WIDTH);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mul <= i_mode_mul;
            if (i_mode_mul) begin
                r_r <= '0;
                r_d <= i_a;
                r_q <= i_b;
            end else begin
                r_r <= '0;
                r_q <= i_a;
                r_d <= i_b;
            end
        end else if (r_busy) begin
            if (r_mul) begin
                if (r_q[0]) begin
                    r_r <= w_acc;
                end
                r_d <= w_base;
                r_q <= r_q >> 1;
            end else if (w_sh >= {1'b0, r_d}) begin
                r_r <= WIDTH'(w_sh - {1'b0, r_d});
                r_q <= {r_q[WIDTH-2:0], 1'b1};
            end else begin
                r_r <= w_sh[WIDTH-1:0];
                r_q <= {r_q[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_q;
    assign o_rem  = r_r;

`ifndef SYNTHESIS
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt == '0) else $error("count nonzero while idle");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("start did not raise busy");
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(r_cnt) == CW'(1)) else $error("step count wrong");
`endif
endmodule

// ===== rtl/core/modular_log_from_collision_top.sv =====
// top level of the collision log recovery block
// depends on mlfc_pkg and mlfc_serial
//
// Recovers x = (c1 - c2) * (d2 - d1)^-1 mod n from a collision of two walks.
// One transaction at a time: the four reductions, each Euclid quotient and
// every modular multiply go through one shared bit-serial unit, and the
// number of Euclid rounds is up to about 1.44*WIDTH. Equal target
// coefficients or a group order below two give the result in the cycle after
// acceptance. A new item is taken only once the previous result has been
// accepted. The group order register is written only while idle.
module modular_log_from_collision_top #(
    parameter int unsigned WIDTH = mlfc_pkg::WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [63:0]      i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [63:0]      i_first_base_coef,
    input  logic [63:0]      i_second_base_coef,
    input  logic [63:0]      i_first_target_coef,
    input  logic [63:0]      i_second_target_coef,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [63:0]      o_log_value,
    output logic [1:0]       o_solve_status
);
    mlfc_pkg::t_state r_state, n_state;
    logic [WIDTH-1:0] r_n;
    logic [WIDTH-1:0] r_c1, r_c2, r_d1, r_d2;
    logic [WIDTH-1:0] r_r0, r_r1, r_t0, r_t1, r_q;
    logic [1:0]       r_idx;
    logic             r_out_valid;
    logic [WIDTH-1:0] r_log;
    logic [1:0]       r_status;

    logic             w_start, w_mode_mul, w_busy, w_early;
    logic [WIDTH-1:0] w_a, w_b, w_quo, w_rem;
    logic [WIDTH-1:0] w_num, w_den, w_tnew;

    assign o_cfg_ready = (r_state == mlfc_pkg::S_IDLE);
    assign o_in_ready  = (r_state == mlfc_pkg::S_IDLE) && !r_out_valid;
    assign w_early     = (i_first_target_coef[WIDTH-1:0] == i_second_target_coef[WIDTH-1:0])
                         || (r_n < WIDTH'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= WIDTH'(mlfc_pkg::GROUP_ORDER_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_n <= i_cfg_data[WIDTH-1:0];
        end
    end

    mlfc_serial #(.WIDTH(WIDTH)) u_serial (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_mode_mul (w_mode_mul),
        .i_a        (w_a),
        .i_b        (w_b),
        .i_n        (r_n),
        .o_busy     (w_busy),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    assign w_num  = (r_c1 >= r_c2) ? r_c1 - r_c2 : r_c1 + (r_n - r_c2);
    assign w_den  = (r_d2 >= r_d1) ? r_d2 - r_d1 : r_d2 + (r_n - r_d1);
    assign w_tnew = (r_t0 >= w_rem) ? r_t0 - w_rem : r_t0 + (r_n - w_rem);

    always_comb begin
        n_state    = r_state;
        w_start    = 1'b0;
        w_mode_mul = 1'b0;
        w_a        = '0;
        w_b        = r_n;
        unique case (r_state)
            mlfc_pkg::S_IDLE: begin
                if (i_in_valid && o_in_ready && !w_early) begin
                    n_state = mlfc_pkg::S_RED;
                end
            end
            mlfc_pkg::S_RED: begin
                unique case (r_idx)
                    2'd0:    w_a = r_c1;
                    2'd1:    w_a = r_c2;
                    2'd2:    w_a = r_d1;
                    default: w_a = r_d2;
                endcase
                w_start = 1'b1;
                n_state = mlfc_pkg::S_DSTEP;
            end
            mlfc_pkg::S_DSTEP: begin
                if (!w_busy) begin
                    n_state = (r_idx == 2'd3) ? mlfc_pkg::S_SUB : mlfc_pkg::S_RED;
                end
            end
            mlfc_pkg::S_SUB: begin
                n_state = mlfc_pkg::S_DIV;
            end
            mlfc_pkg::S_DIV: begin
                if (r_r1 == '0) begin
                    n_state = (r_r0 == WIDTH'(1)) ? mlfc_pkg::S_FMUL : mlfc_pkg::S_DONE;
                end else begin
                    w_a     = r_r0;
                    w_b     = r_r1;
                    w_start = 1'b1;
                    n_state = mlfc_pkg::S_MUL;
                end
            end
            mlfc_pkg::S_MUL: begin
                if (!w_busy) begin
                    n_state = mlfc_pkg::S_MSTEP;
                end
            end
            mlfc_pkg::S_MSTEP: begin
                // q < n always since r0 <= n and r1 >= 1, except r1 == 1 at r0 == n
                w_a        = r_t1;
                w_b        = (r_q >= r_n) ? r_q - r_n : r_q;
                w_mode_mul = 1'b1;
                w_start    = 1'b1;
                n_state    = mlfc_pkg::S_TUPD;
            end
            mlfc_pkg::S_TUPD: begin
                if (!w_busy) begin
                    n_state = mlfc_pkg::S_DIV;
                end
            end
            mlfc_pkg::S_FMUL: begin
                w_a        = r_c1;
                w_b        = r_t0;
                w_mode_mul = 1'b1;
                w_start    = 1'b1;
                n_state    = mlfc_pkg::S_FSTEP;
            end
            mlfc_pkg::S_FSTEP: begin
                if (!w_busy) begin
                    n_state = mlfc_pkg::S_DONE;
                end
            end
            mlfc_pkg::S_DONE: begin
                n_state = mlfc_pkg::S_IDLE;
            end
            default: n_state = mlfc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mlfc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == mlfc_pkg::S_IDLE && i_in_valid && o_in_ready) begin
                r_idx <= '0;
                if (w_early) begin
                    r_out_valid <= 1'b1;
                end
            end
            if (r_state == mlfc_pkg::S_DSTEP && !w_busy) begin
                r_idx <= r_idx + 2'd1;
            end
            if (r_state == mlfc_pkg::S_DONE) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mlfc_pkg::S_IDLE && i_in_valid && o_in_ready) begin
            r_c1     <= i_first_base_coef[WIDTH-1:0];
            r_c2     <= i_second_base_coef[WIDTH-1:0];
            r_d1     <= i_first_target_coef[WIDTH-1:0];
            r_d2     <= i_second_target_coef[WIDTH-1:0];
            r_log    <= '0;
            r_status <= (i_first_target_coef[WIDTH-1:0] == i_second_target_coef[WIDTH-1:0])
                        ? mlfc_pkg::ST_EQUAL : mlfc_pkg::ST_NOINV;
        end
        if (r_state == mlfc_pkg::S_DSTEP && !w_busy) begin
            unique case (r_idx)
                2'd0:    r_c1 <= w_rem;
                2'd1:    r_c2 <= w_rem;
                2'd2:    r_d1 <= w_rem;
                default: r_d2 <= w_rem;
            endcase
        end
        if (r_state == mlfc_pkg::S_SUB) begin
            r_c1 <= w_num;
            r_r0 <= r_n;
            r_r1 <= w_den;
            r_t0 <= '0;
            r_t1 <= WIDTH'(1);
        end
        if (r_state == mlfc_pkg::S_MUL && !w_busy) begin
            r_q  <= w_quo;
            r_r0 <= r_r1;
            r_r1 <= w_rem;
        end
        if (r_state == mlfc_pkg::S_TUPD && !w_busy) begin
            r_t0 <= r_t1;
            r_t1 <= w_tnew;
        end
        if (r_state == mlfc_pkg::S_FSTEP && !w_busy) begin
            r_log    <= w_rem;
            r_status <= mlfc_pkg::ST_OK;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_log_value    = 64'(r_log);
    assign o_solve_status = r_status;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_log))
        else $error("result dropped");
    a_zero_log: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != mlfc_pkg::ST_OK |-> r_log == '0)
        else $error("nonzero log on failure");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != mlfc_pkg::S_IDLE |-> !r_out_valid)
        else $error("working while result pending");
`endif
endmodule
